// ===== hdl/button_led_matrix_scanner_core_assert.svh =====
// assertion macros used by the scanner rtl
`ifndef BUTTON_LED_MATRIX_SCANNER_CORE_ASSERT_SVH
`define BUTTON_LED_MATRIX_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define BTNLED_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// next-cycle implication
`define BTNLED_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

// ===== hdl/btnled_pkg.sv =====
`default_nettype none

package btnled_pkg;

   localparam int ROWS       = 8;
   localparam int HOLD_DEPTH = 64;

   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_SET_PIN = 3'd1;
   localparam logic [2:0] CMD_SET_ROW = 3'd2;
   localparam logic [2:0] CMD_RD_BTN  = 3'd3;
   localparam logic [2:0] CMD_RD_LED  = 3'd4;
   localparam logic [2:0] CMD_POLL    = 3'd5;

   localparam logic [1:0] MODE_SHARED = 2'd1;
   localparam logic [1:0] MODE_PIN    = 2'd2;

   localparam logic [1:0] CSR_DELAY = 2'd0;
   localparam logic [1:0] CSR_MODE  = 2'd1;
   localparam logic [1:0] CSR_MASK  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PIN_RD,
      S_PIN_WR,
      S_POLL_ROW,
      S_POLL_BIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] switch_sample;
      logic [5:0] pin_index;
      logic [2:0] row_index;
      logic [7:0] data_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] cathode_drive;
      logic [7:0] anode_drive;
      logic [7:0] read_data;
      logic       event_valid;
      logic [5:0] event_pin;
      logic       event_level;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic       we;
      logic [5:0] addr;
      logic [7:0] wdata;
   } holdoff_req_type;

endpackage

`default_nettype wire

// ===== hdl/btnled_holdoff_mem.sv =====
`default_nettype none

module btnled_holdoff_mem
   import btnled_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire holdoff_req_type mem_req,
   output logic [7:0]           rd_data
);

   logic [7:0] mem_ff [HOLD_DEPTH];
   logic       valid_ff [HOLD_DEPTH];
   logic [7:0] rdata_ff;
   logic       rvalid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff <= mem_ff[mem_req.addr];
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOLD_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rvalid_ff <= 1'b0;
      end else begin
         if (mem_req.we) begin
            valid_ff[mem_req.addr] <= 1'b1;
         end
         rvalid_ff <= valid_ff[mem_req.addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : 8'h00;

endmodule

`default_nettype wire

// ===== hdl/button_led_matrix_scanner_core.sv =====
// most commands pass S_EXEC then S_FINISH before their result is registered; a scan tick in
// per-pin debounce mode steps one pin counter at a time, S_PIN_RD then S_PIN_WR, through the
// single-port hold-off memory. a poll walks all 64 flags one bit a cycle, holding on a flagged
// bit while the output is busy, with an S_POLL_ROW step per row. one request at a time; next
// accepted once the last result is in the output register. synchronous reset: column 0,
// buttons 0xff, flags, leds, shared counter and control registers zero; no clearing pass.
`default_nettype none

`include "button_led_matrix_scanner_core_assert.svh"

module button_led_matrix_scanner_core
   import btnled_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_index,
   input  wire logic [7:0]      csr_data
);

   state_type       state_ff, state_in;
   req_payload_type req_ff, req_in;
   rsp_payload_type pend_ff, pend_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            pend_valid_ff, pend_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [2:0] col_ff, col_in;
   logic [2:0] prev_ff, prev_in;
   logic [2:0] bit_ff, bit_in;
   logic [2:0] prow_ff, prow_in;
   logic [7:0] chrow_ff, chrow_in;
   logic [7:0] lvlrow_ff, lvlrow_in;
   logic [7:0] shared_ff, shared_in;
   logic [7:0] delay_ff, delay_in;
   logic [1:0] mode_ff, mode_in;
   logic [7:0] mask_ff, mask_in;

   logic [7:0] btn_ff [ROWS];
   logic [7:0] btn_in [ROWS];
   logic [7:0] flag_ff [ROWS];
   logic [7:0] flag_in [ROWS];
   logic [7:0] led_ff [ROWS];
   logic [7:0] led_in [ROWS];

   logic [2:0] btn_idx, led_idx, col_next;
   logic [7:0] btn_rd, flag_rd, led_rd;
   logic [7:0] hold, ch, mem_rd;
   logic       chg, out_free;

   holdoff_req_type mem_req;

   btnled_holdoff_mem u_holdoff (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd)
   );

   assign col_next    = col_ff + 3'd1;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // one row port for button levels and flags, one for leds
   always_comb begin
      if (state_ff == S_POLL_ROW) begin
         btn_idx = prow_ff;
      end else if (state_ff == S_PIN_WR) begin
         btn_idx = prev_ff;
      end else if (req_ff.command == CMD_RD_BTN) begin
         btn_idx = req_ff.row_index;
      end else begin
         btn_idx = col_ff;
      end

      if (req_ff.command == CMD_SET_PIN) begin
         led_idx = req_ff.pin_index[5:3];
      end else if (req_ff.command == CMD_SET_ROW || req_ff.command == CMD_RD_LED) begin
         led_idx = req_ff.row_index;
      end else begin
         led_idx = col_next;
      end
   end

   assign btn_rd  = btn_ff[btn_idx];
   assign flag_rd = flag_ff[btn_idx];
   assign led_rd  = led_ff[led_idx];

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      col_in        = col_ff;
      prev_in       = prev_ff;
      bit_in        = bit_ff;
      prow_in       = prow_ff;
      chrow_in      = chrow_ff;
      lvlrow_in     = lvlrow_ff;
      shared_in     = shared_ff;
      delay_in      = delay_ff;
      mode_in       = mode_ff;
      mask_in       = mask_ff;
      btn_in        = btn_ff;
      flag_in       = flag_ff;
      led_in        = led_ff;
      hold          = shared_ff;
      ch            = req_ff.switch_sample ^ btn_rd;
      chg           = ch[bit_ff];
      mem_req.we    = 1'b0;
      mem_req.addr  = {prev_ff, bit_ff};
      mem_req.wdata = 8'h00;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY: delay_in = csr_data;
            CSR_MODE:  mode_in  = csr_data[1:0];
            CSR_MASK:  mask_in  = csr_data;
            default:   ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               pend_valid_in = 1'b0;
               state_in      = S_EXEC;
            end
         end

         S_EXEC: begin
            pend_in       = '0;
            pend_valid_in = 1'b1;
            state_in      = S_FINISH;
            unique case (req_ff.command)
               CMD_TICK: begin
                  col_in                = col_next;
                  prev_in               = col_ff;
                  pend_in.cathode_drive = ~(8'h01 << col_next) ^ mask_ff;
                  pend_in.anode_drive   = (int'(col_next) < ROWS) ? led_rd : 8'h00;
                  if (mode_ff == MODE_SHARED && shared_ff != 8'h00) begin
                     hold = shared_ff - 8'd1;
                  end
                  shared_in = hold;
                  if (int'(col_ff) < ROWS) begin
                     if (mode_ff == MODE_PIN) begin
                        bit_in   = 3'd0;
                        state_in = S_PIN_RD;
                     end else if (mode_ff != MODE_SHARED || hold == 8'h00) begin
                        flag_in[btn_idx] = flag_rd | ch;
                        btn_in[btn_idx]  = req_ff.switch_sample;
                        if (mode_ff == MODE_SHARED && ch != 8'h00) begin
                           shared_in = delay_ff;
                        end
                     end
                  end
               end
               CMD_SET_PIN: begin
                  if (int'(req_ff.pin_index) < 8 * ROWS) begin
                     led_in[led_idx][req_ff.pin_index[2:0]] = (req_ff.data_value != 8'h00);
                  end
               end
               CMD_SET_ROW: begin
                  if (int'(req_ff.row_index) < ROWS) begin
                     led_in[led_idx] = req_ff.data_value;
                  end
               end
               CMD_RD_BTN: begin
                  pend_in.read_data = (int'(req_ff.row_index) < ROWS) ? btn_rd : 8'hff;
               end
               CMD_RD_LED: begin
                  pend_in.read_data = (int'(req_ff.row_index) < ROWS) ? led_rd : 8'hff;
               end
               CMD_POLL: begin
                  pend_valid_in = 1'b0;
                  prow_in       = 3'd0;
                  state_in      = S_POLL_ROW;
               end
               default: ;
            endcase
         end

         S_PIN_RD: begin
            state_in = S_PIN_WR;
         end

         // one pin counter per visit: count down, or take a change and reload
         S_PIN_WR: begin
            mem_req.we = 1'b1;
            if (mem_rd != 8'h00) begin
               mem_req.wdata = mem_rd - 8'd1;
            end else if (chg) begin
               mem_req.wdata                = delay_ff;
               btn_in[btn_idx][bit_ff]  = req_ff.switch_sample[bit_ff];
               flag_in[btn_idx][bit_ff] = 1'b1;
            end
            if (bit_ff == 3'd7) begin
               state_in = S_FINISH;
            end else begin
               bit_in   = bit_ff + 3'd1;
               state_in = S_PIN_RD;
            end
         end

         S_POLL_ROW: begin
            chrow_in         = flag_rd;
            lvlrow_in        = btn_rd;
            flag_in[btn_idx] = 8'h00;
            bit_in           = 3'd0;
            state_in         = S_POLL_BIT;
         end

         // an event waits in pend until the next one shows it was not the last
         S_POLL_BIT: begin
            if (!(chrow_ff[bit_ff] && pend_valid_ff && !out_free)) begin
               if (chrow_ff[bit_ff]) begin
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in             = '0;
                  pend_in.event_valid = 1'b1;
                  pend_in.event_pin   = {prow_ff, bit_ff};
                  pend_in.event_level = lvlrow_ff[bit_ff];
                  pend_valid_in       = 1'b1;
               end
               if (bit_ff == 3'd7) begin
                  if (prow_ff == 3'(ROWS - 1)) begin
                     state_in = S_FINISH;
                  end else begin
                     prow_in  = prow_ff + 3'd1;
                     state_in = S_POLL_ROW;
                  end
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_in        = pend_valid_ff ? pend_ff : '0;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         col_ff        <= 3'd0;
         shared_ff     <= 8'h00;
         delay_ff      <= 8'h00;
         mode_ff       <= 2'd0;
         mask_ff       <= 8'h00;
         for (int i = 0; i < ROWS; i++) begin
            btn_ff[i]  <= 8'hff;
            flag_ff[i] <= 8'h00;
            led_ff[i]  <= 8'h00;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         col_ff        <= col_in;
         shared_ff     <= shared_in;
         delay_ff      <= delay_in;
         mode_ff       <= mode_in;
         mask_ff       <= mask_in;
         btn_ff        <= btn_in;
         flag_ff       <= flag_in;
         led_ff        <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
      prev_ff   <= prev_in;
      bit_ff    <= bit_in;
      prow_ff   <= prow_in;
      chrow_ff  <= chrow_in;
      lvlrow_ff <= lvlrow_in;
   end

   `BTNLED_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `BTNLED_ASSERT_IMP(a_idle_no_pending, clock, reset, state_ff == S_IDLE, !pend_valid_ff)
   `BTNLED_ASSERT_IMP(a_pin_wr_after_rd, clock, reset, state_ff == S_PIN_WR, $past(state_ff) == S_PIN_RD)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import btnled_pkg::*;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_OFF_ALT = 2'd3;

   localparam int CYCLE_LIMIT      = 1_200_000;
   localparam int DRAIN_CYCLES     = 100;
   localparam int RANDOM_PER_PHASE = 54;
   localparam int DIRECTED_COUNT   = 25;
   localparam int PHASE_COUNT      = 8;

   // event valid, pin and level all clear
   localparam logic [7:0]      NO_EVENT = 8'h00;
   localparam rsp_payload_type ANY_RSP  = '0;

   typedef struct packed {
      req_payload_type item;
      logic            typed;
      rsp_payload_type want;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] delay;
      logic [1:0] mode;
      logic [7:0] mask;
   } csr_setting_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_PERIODIC,
      SINK_SPARSE
   } sink_style_type;

   localparam csr_setting_type RESET_SETTING = {8'd0, MODE_OFF, 8'h00};

   localparam csr_setting_type CSR_PHASES [PHASE_COUNT] = '{
      {8'd0,   MODE_OFF,     8'h00},
      {8'd3,   MODE_SHARED,  8'hff},
      {8'd255, MODE_SHARED,  8'h5a},
      {8'd2,   MODE_PIN,     8'ha5},
      {8'd255, MODE_PIN,     8'h00},
      {8'd0,   MODE_PIN,     8'h3c},
      {8'd7,   MODE_OFF_ALT, 8'hff},
      {8'd1,   MODE_SHARED,  8'h0f}
   };

   // item {command, sample, pin, row, data}, typed flag, {cathode, anode, read, events, last}
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      {{CMD_RD_BTN,  8'h00, 6'd0,  3'd0, 8'h00}, 1'b1, {8'h00, 8'h00, 8'hff, NO_EVENT, 1'b1}},
      {{CMD_RD_LED,  8'h00, 6'd0,  3'd7, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      // nothing flagged yet
      {{CMD_POLL,    8'hff, 6'd63, 3'd7, 8'hff}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_SPARE_6, 8'hff, 6'd63, 3'd7, 8'hff}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_SPARE_7, 8'h00, 6'd0,  3'd0, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_TICK,    8'h00, 6'd0,  3'd0, 8'h00}, 1'b1, {8'hfd, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_SET_ROW, 8'h00, 6'd0,  3'd2, 8'hff}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_SET_PIN, 8'h00, 6'd63, 3'd0, 8'h01}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_SET_PIN, 8'hff, 6'd0,  3'd7, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_RD_LED,  8'h00, 6'd0,  3'd7, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h80, NO_EVENT, 1'b1}},
      {{CMD_SET_PIN, 8'h00, 6'd17, 3'd0, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_RD_LED,  8'h00, 6'd0,  3'd2, 8'h00}, 1'b1, {8'h00, 8'h00, 8'hfd, NO_EVENT, 1'b1}},
      {{CMD_TICK,    8'ha5, 6'd0,  3'd0, 8'h00}, 1'b1, {8'hfb, 8'hfd, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_RD_BTN,  8'h00, 6'd0,  3'd1, 8'h00}, 1'b1, {8'h00, 8'h00, 8'ha5, NO_EVENT, 1'b1}},
      {{CMD_POLL,    8'h00, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP},
      {{CMD_POLL,    8'h00, 6'd0,  3'd0, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_TICK,    8'hff, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP},
      {{CMD_TICK,    8'h00, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP},
      {{CMD_TICK,    8'h0f, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP},
      {{CMD_TICK,    8'hf0, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP},
      {{CMD_TICK,    8'h3c, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP},
      // column wraps from 7 back to 0
      {{CMD_TICK,    8'h81, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP},
      {{CMD_SET_ROW, 8'h00, 6'd0,  3'd7, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00, NO_EVENT, 1'b1}},
      {{CMD_RD_BTN,  8'h00, 6'd0,  3'd7, 8'h00}, 1'b0, ANY_RSP},
      {{CMD_POLL,    8'h00, 6'd0,  3'd0, 8'h00}, 1'b0, ANY_RSP}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b1;
   rsp_payload_type rsp_payload;
   logic            csr_we = 1'b0;
   logic [1:0]      csr_index = CSR_DELAY;
   logic [7:0]      csr_data = 8'h00;

   // predicted scanner state
   logic [7:0] cfg_delay;
   logic [1:0] cfg_mode;
   logic [7:0] cfg_mask;
   logic [2:0] scan_col;
   logic [7:0] btn_lvl [ROWS];
   logic [7:0] chg_flag [ROWS];
   logic [7:0] led_lvl [ROWS];
   logic [7:0] shared_hold;
   logic [7:0] pin_hold [HOLD_DEPTH];

   rsp_payload_type result_due [$];
   rsp_payload_type result_want;
   logic [7:0]      key_state [ROWS];
   int              mismatch_count = 0;
   int unsigned     cycle_count = 0;
   int              burst_left = 0;

   sink_style_type  sink_style = SINK_OPEN;
   int              sink_left = 0;
   int              sink_period = 2;
   int              sink_phase = 0;

   button_led_matrix_scanner_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void settle_row(input logic [2:0] r, input logic [7:0] smp);
      logic [7:0] ch;
      int         b;
      int         p;
      if (cfg_mode == MODE_PIN) begin
         for (b = 0; b < 8; b++) begin
            p = r * 8 + b;
            if (pin_hold[p] != 8'h00) begin
               pin_hold[p] = pin_hold[p] - 8'd1;
            end else if (smp[b] != btn_lvl[r][b]) begin
               btn_lvl[r][b] = smp[b];
               chg_flag[r][b] = 1'b1;
               pin_hold[p] = cfg_delay;
            end
         end
      end else if (cfg_mode != MODE_SHARED || shared_hold == 8'h00) begin
         ch = smp ^ btn_lvl[r];
         chg_flag[r] = chg_flag[r] | ch;
         btn_lvl[r] = smp;
         if (cfg_mode == MODE_SHARED && ch != 8'h00) shared_hold = cfg_delay;
      end
   endfunction

   // queues every result one request should produce
   function automatic void scan_matrix_step(input req_payload_type item);
      rsp_payload_type r;
      rsp_payload_type held;
      logic            have_held;
      logic [2:0]      prev_col;
      int              rr;
      int              b;
      r = '0;
      r.last = 1'b1;
      have_held = 1'b0;
      held = '0;
      case (item.command)
         CMD_TICK: begin
            prev_col = scan_col;
            scan_col = scan_col + 3'd1;
            r.cathode_drive = ~(8'd1 << scan_col) ^ cfg_mask;
            r.anode_drive = led_lvl[scan_col];
            if (cfg_mode == MODE_SHARED && shared_hold != 8'h00) shared_hold = shared_hold - 8'd1;
            settle_row(prev_col, item.switch_sample);
            result_due.push_back(r);
         end
         CMD_SET_PIN: begin
            led_lvl[item.pin_index[5:3]][item.pin_index[2:0]] = (item.data_value != 8'h00);
            result_due.push_back(r);
         end
         CMD_SET_ROW: begin
            led_lvl[item.row_index] = item.data_value;
            result_due.push_back(r);
         end
         CMD_RD_BTN: begin
            r.read_data = btn_lvl[item.row_index];
            result_due.push_back(r);
         end
         CMD_RD_LED: begin
            r.read_data = led_lvl[item.row_index];
            result_due.push_back(r);
         end
         CMD_POLL: begin
            for (rr = 0; rr < ROWS; rr++) begin
               for (b = 0; b < 8; b++) begin
                  if (chg_flag[rr][b]) begin
                     if (have_held) result_due.push_back(held);
                     held = '0;
                     held.event_valid = 1'b1;
                     held.event_pin = 6'(rr * 8 + b);
                     held.event_level = btn_lvl[rr][b];
                     have_held = 1'b1;
                  end
               end
               chg_flag[rr] = 8'h00;
            end
            if (have_held) begin
               held.last = 1'b1;
               result_due.push_back(held);
            end else begin
               result_due.push_back(r);
            end
         end
         default: begin
            result_due.push_back(r);
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_item(input req_payload_type item, input logic typed,
                            input rsp_payload_type want);
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      scan_matrix_step(item);
      // directed rows with a hand-written answer replace the predicted one
      if (typed) begin
         void'(result_due.pop_back());
         result_due.push_back(want);
      end
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (result_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      case (index)
         CSR_DELAY: cfg_delay = data;
         CSR_MODE:  cfg_mode = data[1:0];
         default:   cfg_mask = data;
      endcase
   endtask

   task automatic program_csr(input csr_setting_type s);
      write_csr(CSR_DELAY, s.delay);
      write_csr(CSR_MODE, {6'd0, s.mode});
      write_csr(CSR_MASK, s.mask);
      csr_we <= 1'b0;
   endtask

   // receiver stalls, switching style every so often
   always @(posedge clock) begin
      sink_phase <= sink_phase + 1;
      if (sink_left == 0) begin
         sink_style <= sink_style_type'($urandom_range(0, 3));
         sink_period <= $urandom_range(2, 8);
         sink_left <= $urandom_range(16, 160);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_style)
         SINK_OPEN:     rsp_ready <= 1'b1;
         SINK_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         SINK_PERIODIC: rsp_ready <= (sink_phase % sink_period == 0);
         default:       rsp_ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_due.size() == 0) begin
            $error("result transfer with nothing expected: 0x%0h", rsp_payload);
            mismatch_count++;
         end else begin
            result_want = result_due.pop_front();
            check_field("cathode_drive", result_want.cathode_drive, rsp_payload.cathode_drive);
            check_field("anode_drive", result_want.anode_drive, rsp_payload.anode_drive);
            check_field("read_data", result_want.read_data, rsp_payload.read_data);
            check_field("event_valid", result_want.event_valid, rsp_payload.event_valid);
            check_field("event_pin", result_want.event_pin, rsp_payload.event_pin);
            check_field("event_level", result_want.event_level, rsp_payload.event_level);
            check_field("last", result_want.last, rsp_payload.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req_payload_type item;
      int              pick;
      int              noise;
      int              i;
      int              ph;
      cfg_delay = 8'h00;
      cfg_mode = MODE_OFF;
      cfg_mask = 8'h00;
      scan_col = 3'd0;
      shared_hold = 8'h00;
      for (i = 0; i < ROWS; i++) begin
         btn_lvl[i] = 8'hff;
         chg_flag[i] = 8'h00;
         led_lvl[i] = 8'h00;
         key_state[i] = 8'hff;
      end
      for (i = 0; i < HOLD_DEPTH; i++) pin_hold[i] = 8'h00;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      program_csr(RESET_SETTING);

      for (i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
         pace_sender();
      end

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_idle();
         program_csr(CSR_PHASES[ph]);
         repeat (RANDOM_PER_PHASE) begin
            item.switch_sample = 8'($urandom);
            item.pin_index = 6'($urandom);
            item.row_index = 3'($urandom);
            item.data_value = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               item.command = CMD_TICK;
               // mostly a held key pattern that changes now and then, with bounces and noise
               if ($urandom_range(0, 3) == 0)
                  key_state[scan_col] = key_state[scan_col] ^ (8'd1 << $urandom_range(0, 7));
               noise = $urandom_range(0, 15);
               if (noise == 1 || noise == 2)
                  item.switch_sample = key_state[scan_col] ^ (8'd1 << $urandom_range(0, 7));
               else if (noise != 0)
                  item.switch_sample = key_state[scan_col];
            end else if (pick < 70) begin
               item.command = CMD_POLL;
            end else if (pick < 78) begin
               item.command = CMD_SET_PIN;
               if ($urandom_range(0, 1) == 0) item.data_value = 8'h00;
            end else if (pick < 84) begin
               item.command = CMD_SET_ROW;
            end else if (pick < 90) begin
               item.command = CMD_RD_BTN;
            end else if (pick < 96) begin
               item.command = CMD_RD_LED;
            end else begin
               item.command = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
            end
            send_item(item, 1'b0, ANY_RSP);
            pace_sender();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
